### rtl/pvhe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pvhe_pkg;

    // item kinds on the action input
    typedef enum logic [2:0] {
        ACT_NULL   = 3'd0,
        ACT_BOOL   = 3'd1,
        ACT_INT    = 3'd2,
        ACT_FLOAT  = 3'd3,
        ACT_STRING = 3'd4,
        ACT_LIST   = 3'd5,
        ACT_MAP    = 3'd6,
        ACT_STRUCT = 3'd7
    } t_action;

    // fixed markers
    localparam logic [7:0] MK_NULL  = 8'hC0;
    localparam logic [7:0] MK_FLOAT = 8'hC1;
    localparam logic [7:0] MK_FALSE = 8'hC2;
    localparam logic [7:0] MK_TRUE  = 8'hC3;
    localparam logic [7:0] MK_INT8  = 8'hC8;
    localparam logic [7:0] MK_INT16 = 8'hC9;
    localparam logic [7:0] MK_INT32 = 8'hCA;
    localparam logic [7:0] MK_INT64 = 8'hCB;

    // length header markers: tiny is {2'b10, kind, n}, sized forms are {4'hD, kind, size}
    localparam logic [1:0] TINY_TOP = 2'b10;
    localparam logic [3:0] SIZED_TOP = 4'hD;
    localparam logic [1:0] SZ_8  = 2'b00;
    localparam logic [1:0] SZ_16 = 2'b01;
    localparam logic [1:0] SZ_32 = 2'b10;

    // one classified item: up to nine bytes, left-justified, sent msb byte first
    localparam int WORD_W = 72;
    localparam int CNT_W  = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
        logic              err;
    } t_desc;

endpackage
`default_nettype wire

### rtl/pvhe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pvhe_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_action,
    input  wire logic signed [63:0]   i_value,
    input  wire logic [31:0]          i_payload_length,
    input  wire logic [7:0]           i_signature,
    output logic                      o_desc_valid,
    input  wire logic                 i_desc_ready,
    output pvhe_pkg::t_desc           o_desc
);
    import pvhe_pkg::*;

    logic   r_valid;
    t_desc  r_desc;
    t_desc  n_desc;
    t_desc  hdr;
    logic [1:0] kind;
    logic   fits_tiny;
    logic   fits_8;
    logic   fits_16;
    logic   fits_32;
    logic   is_true;
    logic   in_acc;

    // signed range checks by sign-extension of the upper bits
    assign fits_tiny = (i_value[63:7] == '0) || (i_value[63:4] == '1);
    assign fits_8    = (i_value[63:7] == '0) || (i_value[63:7] == '1);
    assign fits_16   = (i_value[63:15] == '0) || (i_value[63:15] == '1);
    assign fits_32   = (i_value[63:31] == '0) || (i_value[63:31] == '1);
    assign is_true   = !i_value[63] && (i_value != '0);
    assign kind      = i_action[1:0];

    // length header in its smallest form
    always_comb begin
        hdr = '0;
        if (i_payload_length < 32'd16) begin
            hdr.bytes = {TINY_TOP, kind, i_payload_length[3:0], 64'd0};
            hdr.count = 4'd1;
        end else if (i_payload_length < 32'd256) begin
            hdr.bytes = {SIZED_TOP, kind, SZ_8, i_payload_length[7:0], 56'd0};
            hdr.count = 4'd2;
        end else if (i_payload_length < 32'd65536) begin
            hdr.bytes = {SIZED_TOP, kind, SZ_16, i_payload_length[15:0], 48'd0};
            hdr.count = 4'd3;
        end else begin
            hdr.bytes = {SIZED_TOP, kind, SZ_32, i_payload_length, 32'd0};
            hdr.count = 4'd5;
        end
    end

    // classify the request into a byte word and a byte count
    always_comb begin
        n_desc = '0;
        unique case (t_action'(i_action))
            ACT_NULL: begin
                n_desc.bytes = {MK_NULL, 64'd0};
                n_desc.count = 4'd1;
            end
            ACT_BOOL: begin
                n_desc.bytes = {(is_true ? MK_TRUE : MK_FALSE), 64'd0};
                n_desc.count = 4'd1;
            end
            ACT_INT: begin
                priority if (fits_tiny) begin
                    n_desc.bytes = {i_value[7:0], 64'd0};
                    n_desc.count = 4'd1;
                end else if (fits_8) begin
                    n_desc.bytes = {MK_INT8, i_value[7:0], 56'd0};
                    n_desc.count = 4'd2;
                end else if (fits_16) begin
                    n_desc.bytes = {MK_INT16, i_value[15:0], 48'd0};
                    n_desc.count = 4'd3;
                end else if (fits_32) begin
                    n_desc.bytes = {MK_INT32, i_value[31:0], 32'd0};
                    n_desc.count = 4'd5;
                end else begin
                    n_desc.bytes = {MK_INT64, i_value};
                    n_desc.count = 4'd9;
                end
            end
            ACT_FLOAT: begin
                n_desc.bytes = {MK_FLOAT, i_value};
                n_desc.count = 4'd9;
            end
            ACT_STRING, ACT_LIST, ACT_MAP: begin
                n_desc = hdr;
            end
            ACT_STRUCT: begin
                if (i_payload_length > 32'd65535) begin
                    // overflow: one zero byte flagged as error
                    n_desc.bytes = '0;
                    n_desc.count = 4'd1;
                    n_desc.err   = 1'b1;
                end else begin
                    // signature byte follows the header
                    n_desc.bytes = hdr.bytes;
                    unique case (hdr.count)
                        4'd1:    n_desc.bytes[63:56] = i_signature;
                        4'd2:    n_desc.bytes[55:48] = i_signature;
                        default: n_desc.bytes[47:40] = i_signature;
                    endcase
                    n_desc.count = hdr.count + 4'd1;
                end
            end
            default: n_desc = '0;
        endcase
    end

    // one register stage toward the queue
    assign o_in_ready   = !r_valid || i_desc_ready;
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
        end else if (i_desc_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_desc <= n_desc;
        end
    end

endmodule
`default_nettype wire

### rtl/pvhe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pvhe_queue #(
    parameter int DEPTH = pvhe_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_not_full,
    input  wire pvhe_pkg::t_desc   i_desc,
    input  wire logic              i_pop,
    output logic                   o_not_empty,
    output pvhe_pkg::t_desc        o_desc
);
    import pvhe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W_Q-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_not_full  = (r_cnt != CNT_W_Q'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_desc      = r_mem[r_rd];

    // pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W_Q'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W_Q'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule
`default_nettype wire

### rtl/pvhe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pvhe_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_desc_avail,
    output logic                   o_desc_pop,
    input  wire pvhe_pkg::t_desc   i_desc,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_last,
    output logic                   o_error
);
    import pvhe_pkg::*;

    logic                r_busy;
    logic [WORD_W-1:0]   r_word;
    logic [CNT_W-1:0]    r_left;
    logic                r_err;
    logic                out_acc;
    logic                can_load;

    assign o_out_valid = r_busy;
    assign o_out_byte  = r_word[WORD_W-1 -: 8];
    assign o_last      = (r_left == CNT_W'(1));
    assign o_error     = r_err;
    assign out_acc     = r_busy && i_out_ready;
    assign can_load    = !r_busy || (out_acc && o_last);
    assign o_desc_pop  = can_load && i_desc_avail;

    // control: busy while bytes of an item remain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (can_load) begin
            r_busy <= i_desc_avail;
            r_left <= i_desc_avail ? i_desc.count : '0;
        end else if (out_acc) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    // byte shifter, msb byte goes out first
    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_word <= i_desc.bytes;
            r_err  <= i_desc.err;
        end else if (out_acc) begin
            r_word <= {r_word[WORD_W-9:0], 8'h00};
        end
    end

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> o_last)
        else $error("error byte is not the last byte of its item");

    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_left != '0) && (r_left <= CNT_W'(9)))
        else $error("serializer busy with bad byte count");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last && !i_desc_avail) |=> !o_out_valid)
        else $error("serializer stays busy after its final byte");

endmodule
`default_nettype wire

### rtl/packstream_value_header_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Value header encoder: each input request (null, boolean, integer, float, or a
// string/list/map/struct length header) is turned into its marker byte and fixed
// big-endian data bytes, one byte per output request, with o_last on the final
// byte; integers and lengths take their smallest form and a struct adds its
// signature byte. A struct field count above 65535 yields a single zero byte with
// o_error and o_last set. An item has one to nine bytes, one per output transfer;
// the byte serializer at the back sets the output pace, while a register stage and a
// short queue in front let new requests be classified and taken while earlier
// items are still being sent. The first byte of an item is offered once its
// request has passed the front register, the queue and the serializer register.
module packstream_value_header_encoder_core #(
    parameter int QUEUE_DEPTH = pvhe_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_action,
    input  wire logic signed [63:0]   i_value,
    input  wire logic [31:0]          i_payload_length,
    input  wire logic [7:0]           i_signature,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_out_byte,
    output logic                      o_last,
    output logic                      o_error
);
    import pvhe_pkg::*;

    logic   f_valid;
    logic   q_not_full;
    logic   q_not_empty;
    logic   b_pop;
    t_desc  f_desc;
    t_desc  q_desc;

    // front: classify requests
    pvhe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_value          (i_value),
        .i_payload_length (i_payload_length),
        .i_signature      (i_signature),
        .o_desc_valid     (f_valid),
        .i_desc_ready     (q_not_full),
        .o_desc           (f_desc)
    );

    // queue between classifier and serializer
    pvhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (q_not_full),
        .i_desc      (f_desc),
        .i_pop       (b_pop),
        .o_not_empty (q_not_empty),
        .o_desc      (q_desc)
    );

    // back: send bytes
    pvhe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_avail (q_not_empty),
        .o_desc_pop   (b_pop),
        .i_desc       (q_desc),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule
`default_nettype wire
